// ===== sv/kor_pkg.sv =====
// Shared types and constants of the keyword and operator recognizer.
// Used by kor_transition, kor_scanner and keyword_operator_recognizer.
// No dependencies.
package kor_pkg;

   localparam int CH_W    = 8;
   localparam int CODE_W  = 5;
   localparam int ADV_W   = 8;

   localparam logic [ADV_W-1:0] ADVANCE_MAX = 8'd255;

   localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_W-1:0] CH_BANG  = 8'h21;
   localparam logic [CH_W-1:0] CH_QUOTE = 8'h22;
   localparam logic [CH_W-1:0] CH_Z     = 8'h7A;

   typedef enum logic [5:0] {
      S_INIT, S_T1, S_T2, S_V1, S_V2, S_I1, S_I2, S_I3, S_I4, S_BANG,
      S_W1, S_W2, S_W3, S_W4, S_P1, S_P2, S_P3, S_P4,
      S_E1, S_E2, S_E3, S_E4, S_S1, S_S2, S_S3, S_F1, S_F2, S_F3,
      S_R1, S_R2, S_R3, S_R4, S_R5, S_EQ, S_PLUS, S_MINUS, S_FINAL
   } scan_state_type;

   typedef enum logic [CODE_W-1:0] {
      TOK_NONE, TOK_QUOTE, TOK_MUL, TOK_DIV, TOK_LPAREN, TOK_RPAREN,
      TOK_COLON, TOK_COMMA, TOK_TAN, TOK_VAR, TOK_IF, TOK_INPUT,
      TOK_WHILE, TOK_PRINT, TOK_ELSE, TOK_ELIF, TOK_SQRT, TOK_FUNC,
      TOK_RETURN, TOK_GT, TOK_LT, TOK_ASSIGN, TOK_EQ, TOK_ADD,
      TOK_ADD_ASSIGN, TOK_SUB, TOK_SUB_ASSIGN, TOK_NE
   } token_code_type;

   // One step of the table: where it goes and the code it carries.
   typedef struct packed {
      scan_state_type next_state;
      token_code_type code;
   } arc_type;

   // What the scanner hands to the output register for the current beat.
   typedef struct packed {
      logic                 emit;
      token_code_type       code;
      logic [ADV_W-1:0]     advance;
   } result_type;

endpackage

// ===== sv/kor_transition.sv =====
// Transition table of the recognizer: current state and character in,
// next state and transition code out. Purely combinational; uses kor_pkg.
module kor_transition import kor_pkg::*; (
   input  scan_state_type  state,
   input  logic [CH_W-1:0] ch,
   output arc_type         arc
);

   arc_type fallback;

   // A character with no arc ends the attempt; after '=', '+' and '-' the
   // pending one-character operator is what gets reported.
   always_comb begin
      unique case (state)
         S_EQ:    fallback = arc_type'{S_FINAL, TOK_ASSIGN};
         S_PLUS:  fallback = arc_type'{S_FINAL, TOK_ADD};
         S_MINUS: fallback = arc_type'{S_FINAL, TOK_SUB};
         default: fallback = arc_type'{S_FINAL, TOK_NONE};
      endcase
   end

   always_comb begin
      arc = fallback;
      unique case (state)
         S_INIT: begin
            unique case (ch)
               CH_SPACE: arc = arc_type'{S_INIT,  TOK_NONE};
               CH_QUOTE: arc = arc_type'{S_FINAL, TOK_QUOTE};
               "*":      arc = arc_type'{S_FINAL, TOK_MUL};
               "/":      arc = arc_type'{S_FINAL, TOK_DIV};
               "(":      arc = arc_type'{S_FINAL, TOK_LPAREN};
               ")":      arc = arc_type'{S_FINAL, TOK_RPAREN};
               ":":      arc = arc_type'{S_FINAL, TOK_COLON};
               ",":      arc = arc_type'{S_FINAL, TOK_COMMA};
               "t":      arc = arc_type'{S_T1,    TOK_NONE};
               "v":      arc = arc_type'{S_V1,    TOK_NONE};
               "i":      arc = arc_type'{S_I1,    TOK_NONE};
               CH_BANG:  arc = arc_type'{S_BANG,  TOK_NONE};
               "w":      arc = arc_type'{S_W1,    TOK_NONE};
               "p":      arc = arc_type'{S_P1,    TOK_NONE};
               "e":      arc = arc_type'{S_E1,    TOK_NONE};
               "s":      arc = arc_type'{S_S1,    TOK_NONE};
               "f":      arc = arc_type'{S_F1,    TOK_NONE};
               "r":      arc = arc_type'{S_R1,    TOK_NONE};
               ">":      arc = arc_type'{S_FINAL, TOK_GT};
               "<":      arc = arc_type'{S_FINAL, TOK_LT};
               "=":      arc = arc_type'{S_EQ,    TOK_ASSIGN};
               "+":      arc = arc_type'{S_PLUS,  TOK_ADD};
               "-":      arc = arc_type'{S_MINUS, TOK_NONE};
               default:  arc = fallback;
            endcase
         end
         S_T1: if (ch == "a") arc = arc_type'{S_T2,    TOK_NONE};
         S_T2: if (ch == "n") arc = arc_type'{S_FINAL, TOK_TAN};
         S_V1: if (ch == "a") arc = arc_type'{S_V2,    TOK_NONE};
         S_V2: if (ch == "r") arc = arc_type'{S_FINAL, TOK_VAR};
         S_I1: begin
            if (ch == "f") arc = arc_type'{S_FINAL, TOK_IF};
            else if (ch == "n") arc = arc_type'{S_I2, TOK_NONE};
         end
         S_I2: if (ch == "p") arc = arc_type'{S_I3,    TOK_NONE};
         S_I3: if (ch == "u") arc = arc_type'{S_I4,    TOK_NONE};
         S_I4: if (ch == "t") arc = arc_type'{S_FINAL, TOK_INPUT};
         S_BANG: if (ch == "=") arc = arc_type'{S_FINAL, TOK_NE};
         S_W1: if (ch == "h") arc = arc_type'{S_W2,    TOK_NONE};
         S_W2: if (ch == "i") arc = arc_type'{S_W3,    TOK_NONE};
         S_W3: if (ch == "l") arc = arc_type'{S_W4,    TOK_NONE};
         S_W4: if (ch == "e") arc = arc_type'{S_FINAL, TOK_WHILE};
         S_P1: if (ch == "r") arc = arc_type'{S_P2,    TOK_NONE};
         S_P2: if (ch == "i") arc = arc_type'{S_P3,    TOK_NONE};
         S_P3: if (ch == "n") arc = arc_type'{S_P4,    TOK_NONE};
         S_P4: if (ch == "t") arc = arc_type'{S_FINAL, TOK_PRINT};
         S_E1: if (ch == "l") arc = arc_type'{S_E2,    TOK_NONE};
         S_E2: begin
            if (ch == "s") arc = arc_type'{S_E3, TOK_NONE};
            else if (ch == "i") arc = arc_type'{S_E4, TOK_NONE};
         end
         S_E3: if (ch == "e") arc = arc_type'{S_FINAL, TOK_ELSE};
         S_E4: if (ch == "f") arc = arc_type'{S_FINAL, TOK_ELIF};
         S_S1: if (ch == "q") arc = arc_type'{S_S2,    TOK_NONE};
         S_S2: if (ch == "r") arc = arc_type'{S_S3,    TOK_NONE};
         S_S3: if (ch == "t") arc = arc_type'{S_FINAL, TOK_SQRT};
         S_F1: if (ch == "u") arc = arc_type'{S_F2,    TOK_NONE};
         S_F2: if (ch == "n") arc = arc_type'{S_F3,    TOK_NONE};
         S_F3: if (ch == "c") arc = arc_type'{S_FINAL, TOK_FUNC};
         S_R1: if (ch == "e") arc = arc_type'{S_R2,    TOK_NONE};
         S_R2: if (ch == "t") arc = arc_type'{S_R3,    TOK_NONE};
         S_R3: if (ch == "u") arc = arc_type'{S_R4,    TOK_NONE};
         S_R4: if (ch == "r") arc = arc_type'{S_R5,    TOK_NONE};
         S_R5: if (ch == "n") arc = arc_type'{S_FINAL, TOK_RETURN};
         S_EQ:    if (ch == "=") arc = arc_type'{S_FINAL, TOK_EQ};
         S_PLUS:  if (ch == "=") arc = arc_type'{S_FINAL, TOK_ADD_ASSIGN};
         S_MINUS: if (ch == "=") arc = arc_type'{S_FINAL, TOK_SUB_ASSIGN};
         default: arc = fallback;
      endcase
   end

endmodule

// ===== sv/kor_scanner.sv =====
// Scan state of the recognizer: table state, pending code and character
// count, plus the result of the current beat. Uses kor_pkg, kor_transition.
module kor_scanner import kor_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [CH_W-1:0] ch,
   output result_type      res
);

   scan_state_type    state_ff, state_in;
   token_code_type    pending_ff, pending_in;
   logic [ADV_W-1:0]  count_ff, count_in;
   logic [ADV_W-1:0]  count_inc;
   arc_type           arc;

   kor_transition u_transition (
      .state (state_ff),
      .ch    (ch),
      .arc   (arc)
   );

   // Bare + and - end on a character they do not consume.
   function automatic logic [ADV_W-1:0] advance_of(token_code_type code,
                                                   logic [ADV_W-1:0] cnt);
      logic [ADV_W-1:0] adv;
      if (code == TOK_NONE) begin
         adv = '0;
      end else if (code == TOK_ADD || code == TOK_SUB) begin
         adv = (cnt != '0) ? cnt - 1'b1 : '0;
      end else begin
         adv = cnt;
      end
      return adv;
   endfunction

   assign count_inc = (count_ff < ADVANCE_MAX) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      res        = '{emit: 1'b0, code: TOK_NONE, advance: '0};
      state_in   = arc.next_state;
      pending_in = arc.code;
      count_in   = count_inc;
      priority if (ch == CH_NUL) begin
         res = '{emit: 1'b1, code: pending_ff,
                 advance: advance_of(pending_ff, count_ff)};
      end else if (ch > CH_Z) begin
         res = '{emit: 1'b1, code: TOK_NONE, advance: '0};
      end else if (arc.next_state == S_FINAL) begin
         res = '{emit: 1'b1, code: arc.code,
                 advance: advance_of(arc.code, count_inc)};
      end
      // Every result starts the next attempt from scratch.
      if (res.emit) begin
         state_in   = S_INIT;
         pending_in = TOK_NONE;
         count_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_INIT;
         pending_ff <= TOK_NONE;
         count_ff   <= '0;
      end else if (step) begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
         count_ff   <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_final_not_held: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_FINAL)
      else $error("scanner holds the final state");

   a_pending_kinds: assert property (@(posedge clock) disable iff (reset)
      pending_ff == TOK_NONE || pending_ff == TOK_ASSIGN || pending_ff == TOK_ADD)
      else $error("pending code is not one that can be reported on a zero byte");

   a_restart_after_result: assert property (@(posedge clock) disable iff (reset)
      step && res.emit |=> state_ff == S_INIT && pending_ff == TOK_NONE
                           && count_ff == '0)
      else $error("scanner did not restart after a result");
`endif

endmodule

// ===== sv/keyword_operator_recognizer.sv =====
// Keyword and operator recognizer, top level.
// Takes one character per beat on the req_ channel and reports each
// recognized token on the rsp_ channel with the number of characters it
// consumed. Leading spaces count toward that number.
// An attempt ends on the table's final state, on a zero byte (not counted)
// or on a byte above 'z' (reported as no token, advance 0).
// Bare + and - report one character less, since the character that ended
// them is not part of the token. The count saturates at 255.
// An accepted character is held in ch_ff and scanned against the scan
// state; a result it ends is registered in code_ff and advance_ff for rsp_.
// Throughput: one character per cycle unless a result waits on rsp_ready;
// the scan state feeds back through the single kor_transition lookup.
// A result waiting in the output register does not stop the scan: beats
// that end no attempt keep flowing, and only a beat that would produce a
// second result waits for rsp_ready.
// Reset empties the input and output registers and restarts the scan.
// Depends on kor_pkg and kor_scanner.
module keyword_operator_recognizer import kor_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CH_W-1:0]    req_ch,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CODE_W-1:0]  rsp_token_code,
   output logic [ADV_W-1:0]   rsp_advance
);

   logic              in_valid_ff, in_valid_in;
   logic [CH_W-1:0]   ch_ff;
   logic              out_valid_ff, out_valid_in;
   token_code_type    code_ff;
   logic [ADV_W-1:0]  advance_ff;
   logic              step;
   result_type        res;

   kor_scanner u_scanner (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .ch    (ch_ff),
      .res   (res)
   );

   assign step      = in_valid_ff && (!res.emit || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step && res.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         ch_ff <= req_ch;
      end
      if (step && res.emit) begin
         code_ff    <= res.code;
         advance_ff <= res.advance;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_token_code = code_ff;
   assign rsp_advance    = advance_ff;

`ifndef NO_ASSERTIONS
   a_none_has_no_advance: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (code_ff != TOK_NONE || advance_ff == '0))
      else $error("result without a token carries a nonzero advance");

   a_code_in_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> code_ff <= TOK_NE)
      else $error("result code out of range");

   a_blocked_beat_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(ch_ff))
      else $error("a blocked input beat was lost or changed");
`endif

endmodule
